@@ rtl/rfe_pkg.sv @@
// Shared types, constants and register map of the Renard frame encoder.
package rfe_pkg;

    localparam int BANK_SIZE = 8;
    localparam int MAX_BYTES = 5;
    localparam int LEN_W     = $clog2(MAX_BYTES + 1);
    localparam int POS_W     = $clog2(MAX_BYTES);
    localparam int ADDR_W    = 4;

    localparam logic [7:0] PAD_BYTE   = 8'h7D;
    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7F;
    localparam logic [7:0] ESC_BASE   = 8'h2F;

    localparam logic [1:0] REG_START_ADDRESS = 2'd0;
    localparam logic [1:0] REG_DMX_OFFSET    = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;
    localparam logic [1:0] REG_PAD_THRESHOLD = 2'd3;

    localparam logic [7:0] START_ADDRESS_RESET = 8'd128;
    localparam logic [8:0] DMX_OFFSET_RESET    = 9'd0;
    localparam logic [9:0] CHANNEL_COUNT_RESET = 10'd64;
    localparam logic [7:0] PAD_THRESHOLD_RESET = 8'd100;

    typedef struct packed {
        logic [8:0] slot_index;
        logic [7:0] slot_level;
    } slot_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } enc_byte_t;

    typedef struct packed {
        logic [7:0] start_address;
        logic [8:0] dmx_offset;
        logic [9:0] channel_count;
        logic [7:0] pad_threshold;
    } cfg_t;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [LEN_W-1:0]          len;
    } burst_t;

endpackage

@@ rtl/rfe_cfg_regs.sv @@
// Configuration register bank with its APB-style access port.
module rfe_cfg_regs
    import rfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic [1:0]  reg_sel;
    logic        wr_en;

    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_START_ADDRESS: cfg_next.start_address = pwdata[7:0];
                REG_DMX_OFFSET:    cfg_next.dmx_offset    = pwdata[8:0];
                REG_CHANNEL_COUNT: cfg_next.channel_count = pwdata[9:0];
                REG_PAD_THRESHOLD: cfg_next.pad_threshold = pwdata[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_START_ADDRESS: prdata = {24'd0, cfg_reg.start_address};
            REG_DMX_OFFSET:    prdata = {23'd0, cfg_reg.dmx_offset};
            REG_CHANNEL_COUNT: prdata = {22'd0, cfg_reg.channel_count};
            REG_PAD_THRESHOLD: prdata = {24'd0, cfg_reg.pad_threshold};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_address <= START_ADDRESS_RESET;
            cfg_reg.dmx_offset    <= DMX_OFFSET_RESET;
            cfg_reg.channel_count <= CHANNEL_COUNT_RESET;
            cfg_reg.pad_threshold <= PAD_THRESHOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/rfe_burst_build.sv @@
// Slot decoder that builds the byte burst for one slot and keeps the running byte count.
module rfe_burst_build
    import rfe_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  slot_t  slot,
    input  logic   take,
    output logic   hit,
    output burst_t burst
);

    logic [7:0]       sent_count_reg;
    logic [7:0]       sent_count_next;
    logic [9:0]       chan_wide;
    logic [8:0]       chan;
    logic             in_window;
    logic             bank_start;
    logic             pad;
    logic             esc;
    logic [7:0]       bank_addr;
    logic [7:0]       base_count;
    logic [2:0]       add_count;
    logic [8:0]       sum_count;
    logic [LEN_W-1:0] n;

    assign chan_wide  = {1'b0, slot.slot_index} - {1'b0, cfg.dmx_offset};
    assign chan       = chan_wide[8:0];
    assign in_window  = !chan_wide[9] && ({1'b0, chan} < cfg.channel_count);
    assign hit        = in_window;
    assign bank_start = ((chan % BANK_SIZE) == 9'd0);
    assign pad        = bank_start && (sent_count_reg >= cfg.pad_threshold);
    assign bank_addr  = 8'(cfg.start_address + 8'(chan / BANK_SIZE));
    assign esc        = (slot.slot_level == PAD_BYTE) || (slot.slot_level == START_BYTE)
                        || (slot.slot_level == ESC_BYTE);

    assign base_count = pad ? 8'd0 : sent_count_reg;
    assign add_count  = (bank_start ? 3'd2 : 3'd0) + (esc ? 3'd2 : 3'd1);
    assign sum_count  = {1'b0, base_count} + {6'd0, add_count};
    assign sent_count_next = sum_count[8] ? 8'hFF : sum_count[7:0];

    always_comb
    begin
        burst.bytes = '0;
        n = '0;
        if (bank_start)
        begin
            if (pad)
            begin
                burst.bytes[0] = PAD_BYTE;
                n = LEN_W'(1);
            end
            burst.bytes[POS_W'(n)] = START_BYTE;
            burst.bytes[POS_W'(n + LEN_W'(1))] = bank_addr;
            n = LEN_W'(n + LEN_W'(2));
        end
        if (esc)
        begin
            burst.bytes[POS_W'(n)] = ESC_BYTE;
            burst.bytes[POS_W'(n + LEN_W'(1))] =
                8'(ESC_BASE + (slot.slot_level - PAD_BYTE));
            n = LEN_W'(n + LEN_W'(2));
        end
        else
        begin
            burst.bytes[POS_W'(n)] = slot.slot_level;
            n = LEN_W'(n + LEN_W'(1));
        end
        burst.len = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_count_reg <= 8'd0;
        end
        else if (take && hit)
        begin
            sent_count_reg <= sent_count_next;
        end
    end

endmodule

@@ rtl/rfe_byte_serial.sv @@
// Burst holding register and output register that send one byte per cycle while the output is not stalled.
module rfe_byte_serial
    import rfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  burst_t    burst,
    output logic      can_load,
    output logic      out_valid,
    input  logic      out_stall,
    output enc_byte_t out_data
);

    logic [MAX_BYTES-1:0][7:0] bytes_reg;
    logic [LEN_W-1:0]          len_reg;
    logic [POS_W-1:0]          pos_reg;
    logic                      busy_reg;
    enc_byte_t                 out_reg;
    logic                      out_valid_reg;
    logic                      out_free;
    logic                      move;
    logic                      last;

    assign out_free  = !out_valid_reg || !out_stall;
    assign move      = busy_reg && out_free;
    assign last      = (pos_reg == POS_W'(len_reg - LEN_W'(1)));
    assign can_load  = !busy_reg || (move && last);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
            if (load)
            begin
                busy_reg <= 1'b1;
                pos_reg  <= '0;
            end
            else if (move)
            begin
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    pos_reg <= POS_W'(pos_reg + POS_W'(1));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_reg.out_byte <= bytes_reg[pos_reg];
            out_reg.run_last <= last;
        end
        if (load)
        begin
            bytes_reg <= burst.bytes;
            len_reg   <= burst.len;
        end
    end

endmodule

@@ rtl/renard_frame_encoder_unit.sv @@
// Top level of the Renard serial frame encoder.
// Each accepted slot inside the channel window yields from one to five serial bytes: an
// optional pad byte, a bank header of two bytes on every eighth channel, and the level,
// escaped to two bytes where needed. Bytes leave one per cycle, when the output is not
// stalled, through a single output register; a slot outside the window is dropped with no
// output. The next slot is taken in the cycle in which the last byte of the current one
// moves to the output.
module renard_frame_encoder_unit
    import rfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  slot_t             in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output enc_byte_t         out_data
);

    cfg_t   cfg;
    burst_t burst;
    logic   hit;
    logic   can_load;
    logic   take;

    assign in_stall = !can_load;
    assign take     = in_valid && can_load;

    rfe_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rfe_burst_build u_burst_build (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .slot  (in_data),
        .take  (take),
        .hit   (hit),
        .burst (burst)
    );

    rfe_byte_serial u_byte_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && hit),
        .burst     (burst),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

@@ rtl/rfe_checker.sv @@
// Port-level checker for the Renard frame encoder and its bind statement.
module rfe_checker
    import rfe_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input enc_byte_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output transfer changed");

    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.run_last |=> out_valid)
        else $error("gap inside the bytes of one slot");

    a_last_not_special: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.run_last |->
            out_data.out_byte != PAD_BYTE && out_data.out_byte != START_BYTE &&
            out_data.out_byte != ESC_BYTE)
        else $error("final byte of a slot is a control byte");

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind renard_frame_encoder_unit rfe_checker u_rfe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

@@ dv/rfe_byte_checker.sv @@
// Checker that predicts the serial bytes of the Renard frame encoder and compares every transfer.
module rfe_byte_checker
    import rfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              in_valid,
    input  logic              in_stall,
    input  slot_t             in_data,
    input  logic              out_valid,
    input  logic              out_stall,
    input  enc_byte_t         out_data,
    output int                fail_count,
    output int                pending_bytes
);

    cfg_t       cfg;
    logic [7:0] byte_count;
    enc_byte_t  expected_bytes[$];

    task automatic count_bytes(input int n);
        int total;
        total = int'(byte_count) + n;
        byte_count = (total > 255) ? 8'd255 : 8'(total);
    endtask

    task automatic encode_slot(input slot_t s);
        logic [9:0] chan;
        logic [7:0] burst[$];
        if (s.slot_index < cfg.dmx_offset)
            return;
        chan = 10'(s.slot_index) - 10'(cfg.dmx_offset);
        if (chan >= cfg.channel_count)
            return;
        if (chan % BANK_SIZE == 0)
        begin
            if (byte_count >= cfg.pad_threshold)
            begin
                burst.push_back(PAD_BYTE);
                byte_count = 8'd0;
            end
            burst.push_back(START_BYTE);
            burst.push_back(8'(cfg.start_address + chan / BANK_SIZE));
            count_bytes(2);
        end
        if (s.slot_level == PAD_BYTE || s.slot_level == START_BYTE || s.slot_level == ESC_BYTE)
        begin
            burst.push_back(ESC_BYTE);
            burst.push_back(ESC_BASE + (s.slot_level - PAD_BYTE));
            count_bytes(2);
        end
        else
        begin
            burst.push_back(s.slot_level);
            count_bytes(1);
        end
        foreach (burst[k])
            expected_bytes.push_back('{out_byte: burst[k], run_last: 1'(k == burst.size() - 1)});
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        enc_byte_t want;
        if (!rst_n)
        begin
            cfg.start_address = START_ADDRESS_RESET;
            cfg.dmx_offset    = DMX_OFFSET_RESET;
            cfg.channel_count = CHANNEL_COUNT_RESET;
            cfg.pad_threshold = PAD_THRESHOLD_RESET;
            byte_count        = 8'd0;
            expected_bytes.delete();
            fail_count        = 0;
            pending_bytes     = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_START_ADDRESS: cfg.start_address = pwdata[7:0];
                    REG_DMX_OFFSET:    cfg.dmx_offset    = pwdata[8:0];
                    REG_CHANNEL_COUNT: cfg.channel_count = pwdata[9:0];
                    REG_PAD_THRESHOLD: cfg.pad_threshold = pwdata[7:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                encode_slot(in_data);
            if (out_valid && !out_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected transfer: out_byte %02h run_last %0b",
                           out_data.out_byte, out_data.run_last);
                    fail_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_data.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %02h, actual %02h",
                               want.out_byte, out_data.out_byte);
                        fail_count++;
                    end
                    if (out_data.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %0b, actual %0b",
                               want.run_last, out_data.run_last);
                        fail_count++;
                    end
                end
            end
            pending_bytes = expected_bytes.size();
        end
    end

endmodule

@@ dv/tb.sv @@
// Top-level testbench of the Renard frame encoder: stimulus, register writes and verdict.
module tb;
    import rfe_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    slot_t             in_data;
    logic              out_valid;
    logic              out_stall = 1'b0;
    enc_byte_t         out_data;

    int         fail_count;
    int         pending_bytes;
    int         idle_pct = 0;
    int         stall_pct = 0;
    int         cycles = 0;
    logic [8:0] win_offset;

    renard_frame_encoder_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    rfe_byte_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .fail_count   (fail_count),
        .pending_bytes(pending_bytes)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_window(input logic [7:0] start, input logic [8:0] offset,
                              input logic [9:0] count, input logic [7:0] threshold);
        write_reg(REG_START_ADDRESS, 32'(start));
        write_reg(REG_DMX_OFFSET, 32'(offset));
        write_reg(REG_CHANNEL_COUNT, 32'(count));
        write_reg(REG_PAD_THRESHOLD, 32'(threshold));
        win_offset = offset;
    endtask

    task automatic send_slot(input logic [8:0] idx, input logic [7:0] lvl);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{slot_index: idx, slot_level: lvl};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Waits until every expected byte has left, then for the odd slot still being dropped.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_bytes != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic logic [7:0] random_level();
        if ($urandom_range(0, 3) == 0)
            return PAD_BYTE + 8'($urandom_range(0, 2));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic run_phase(input int items, input int send_pct, input int hold_pct);
        int sent;
        int base;
        int len;
        logic [8:0] idx;
        sent      = 0;
        idle_pct  = send_pct;
        stall_pct = hold_pct;
        while (sent < items)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                idx = 9'($urandom_range(0, 511));
                sent++;
                send_slot(idx, 8'($urandom_range(0, 255)));
            end
            else
            begin
                base = int'(win_offset) - $urandom_range(0, 3);
                if (base < 0)
                    base = 0;
                len = $urandom_range(1, 40);
                for (int k = 0; k < len && base + k <= 511 && sent < items; k++)
                begin
                    idx = 9'(base + k);
                    sent++;
                    send_slot(idx, random_level());
                end
            end
        end
        settle();
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        in_data    = '0;
        win_offset = DMX_OFFSET_RESET;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Register values after reset, every escaped level, a bank with an escaped level.
        send_slot(9'd0, 8'h00);
        send_slot(9'd1, 8'hFF);
        send_slot(9'd2, PAD_BYTE);
        send_slot(9'd3, START_BYTE);
        send_slot(9'd4, ESC_BYTE);
        send_slot(9'd5, 8'h7C);
        send_slot(9'd6, 8'h80);
        send_slot(9'd8, START_BYTE);
        send_slot(9'd64, 8'h11);
        send_slot(9'd511, 8'h55);
        send_slot(9'd63, 8'hAA);
        settle();

        // A zero pad threshold pads every bank; only the top slot lies in the window.
        set_window(8'd255, 9'd511, 10'd512, 8'd0);
        send_slot(9'd510, 8'h33);
        send_slot(9'd511, ESC_BYTE);
        send_slot(9'd511, 8'h00);
        settle();

        // An empty window drops everything.
        set_window(8'd0, 9'd0, 10'd0, 8'd255);
        send_slot(9'd0, 8'h01);
        send_slot(9'd300, 8'h02);
        settle();

        // An oversized window, a wrapping bank address and a threshold of one.
        set_window(8'd250, 9'd0, 10'd1023, 8'd1);
        send_slot(9'd511, PAD_BYTE);
        send_slot(9'd504, 8'hFF);
        send_slot(9'd0, START_BYTE);
        send_slot(9'd256, 8'h00);
        settle();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: set_window(8'd0, 9'd0, 10'd512, 8'd255);
                1: set_window(8'd255, 9'd0, 10'd64, 8'd1);
                4: set_window(8'($urandom_range(0, 255)), 9'd511, 10'd1023, 8'd0);
                default: set_window(8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)),
                                    10'($urandom_range(1, 1023)), 8'($urandom_range(0, 255)));
            endcase
            case (p % 4)
                0: run_phase(51, 0, 0);
                1: run_phase(51, 79, 0);
                2: run_phase(51, 0, 79);
                default: run_phase(51, 23, 23);
            endcase
        end

        if (fail_count == 0 && pending_bytes == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/rfe_pkg.sv
rtl/rfe_cfg_regs.sv
rtl/rfe_burst_build.sv
rtl/rfe_byte_serial.sv
rtl/renard_frame_encoder_unit.sv
rtl/rfe_checker.sv
dv/rfe_byte_checker.sv
dv/tb.sv
